// ===== design/lane_path_count_matrix_power_top_defines.svh =====
// assertion macros for the lane path counter checker
`ifndef LANE_PATH_COUNT_MATRIX_POWER_TOP_DEFINES_SVH
`define LANE_PATH_COUNT_MATRIX_POWER_TOP_DEFINES_SVH

// same-cycle implication
`define LPCMP_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define LPCMP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/lpcmp_pkg.sv =====
// shared types and constants for the lane path counter
package lpcmp_pkg;

    localparam int VAL_W = 30;

    localparam logic [VAL_W-1:0] MODULUS    = 30'd1000000007;
    localparam logic [31:0]      MOD_TWICE  = 32'd2000000014;
    // floor(2^60 / MODULUS)
    localparam logic [30:0]      BARRETT_MU = 31'd1152921496;

    typedef struct packed {
        logic       last;
        logic       fin;
        logic [3:0] dst;
    } t_tag;

endpackage

// ===== design/lpcmp_if.sv =====
// request channels for segments and results
interface lpcmp_seg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  blocked_rows;
    logic [59:0] segment_length;
    logic        last_segment;

    modport source (output valid, output blocked_rows, output segment_length,
                    output last_segment, input ready);
    modport sink   (input valid, input blocked_rows, input segment_length,
                    input last_segment, output ready);
endinterface

interface lpcmp_res_if;
    logic        valid;
    logic        ready;
    logic [29:0] path_count;

    modport source (output valid, output path_count, input ready);
    modport sink   (input valid, input path_count, output ready);
endinterface

// ===== design/lpcmp_mulmod.sv =====
// pipelined modular multiplier with barrett reduction, one product per cycle
module lpcmp_mulmod
    import lpcmp_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  t_tag             i_tag,
    input  logic [VAL_W-1:0] i_a,
    input  logic [VAL_W-1:0] i_b,
    output logic             o_valid,
    output t_tag             o_tag,
    output logic [VAL_W-1:0] o_res
);

    logic [3:0]       r_vld;
    t_tag             r_tag1;
    t_tag             r_tag2;
    t_tag             r_tag3;
    t_tag             r_tag4;
    logic [59:0]      r_prod;
    logic [30:0]      r_q;
    logic [31:0]      r_plo2;
    logic [31:0]      r_qm;
    logic [31:0]      r_plo3;
    logic [VAL_W-1:0] r_res;

    logic [61:0]      w_t;
    logic [31:0]      w_qm;
    logic [31:0]      w_rem;
    logic [31:0]      w_red;

    assign w_t   = 62'(r_prod[59:29]) * 62'(BARRETT_MU);
    assign w_qm  = 32'(r_q) * 32'(MODULUS);
    assign w_rem = r_plo3 - r_qm;

    always_comb begin
        priority if (w_rem >= MOD_TWICE) begin
            w_red = w_rem - MOD_TWICE;
        end else if (w_rem >= 32'(MODULUS)) begin
            w_red = w_rem - 32'(MODULUS);
        end else begin
            w_red = w_rem;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= 60'(i_a) * 60'(i_b);
        r_tag1 <= i_tag;
        r_q    <= w_t[61:31];
        r_plo2 <= r_prod[31:0];
        r_tag2 <= r_tag1;
        r_qm   <= w_qm;
        r_plo3 <= r_plo2;
        r_tag3 <= r_tag2;
        r_res  <= w_red[VAL_W-1:0];
        r_tag4 <= r_tag3;
    end

    assign o_valid = r_vld[3];
    assign o_tag   = r_tag4;
    assign o_res   = r_res;

endmodule

// ===== design/lane_path_count_matrix_power_top.sv =====
// lane path counter: 3x3 modular matrix power applied to a lane count vector
// segments are taken one at a time, ready only while idle; all products go through the single
//   pipelined modular multiplier, which takes one product a cycle
// reset: synchronous active low, lane counts return to 0,1,0, no result pending
module lane_path_count_matrix_power_top
    import lpcmp_pkg::*;
#(
    parameter int LENGTH_BITS = 60
)
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    lpcmp_seg_if.sink    i_seg,
    lpcmp_res_if.source  o_res
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_BUILD,
        ST_CHECK,
        ST_APPLY,
        ST_NEXT,
        ST_SQUARE,
        ST_FINISH
    } t_state;

    t_state                 r_state;
    logic                   r_bank;
    logic [1:0]             r_i;
    logic [1:0]             r_j;
    logic [1:0]             r_k;
    logic                   r_iss_on;
    logic [LENGTH_BITS-1:0] r_exp;
    logic [2:0]             r_blocked;
    logic                   r_last;
    logic                   r_out_valid;
    logic [VAL_W-1:0]       r_out_count;

    logic [VAL_W-1:0]       r_mem [0:1][0:8];
    logic [VAL_W-1:0]       r_rd_a;
    logic [VAL_W-1:0]       r_rd_b;
    logic                   r_rd_v;
    t_tag                   r_rd_tag;

    logic [VAL_W-1:0]       r_vec  [0:2];
    logic [VAL_W-1:0]       r_vnew [0:2];
    logic [VAL_W-1:0]       r_acc;

    logic [63:0]            w_len_ext;
    logic                   w_accept;
    logic                   w_apply;
    logic                   w_issue;
    logic [3:0]             w_idx_ij;
    logic [3:0]             w_idx_ik;
    logic [3:0]             w_idx_kj;
    t_tag                   w_iss_tag;
    logic                   w_reach;
    logic                   w_we;
    logic                   w_wbank;
    logic [3:0]             w_widx;
    logic [VAL_W-1:0]       w_wdata;
    logic                   w_mul_v;
    t_tag                   w_mul_tag;
    logic [VAL_W-1:0]       w_mul_res;
    logic [VAL_W:0]         w_sum_raw;
    logic [VAL_W-1:0]       w_sum;
    logic                   w_fin;
    logic                   w_emit;

    assign w_len_ext = 64'(i_seg.segment_length);
    assign w_accept  = i_seg.valid && i_seg.ready;
    assign w_apply   = (r_state == ST_APPLY);
    assign w_issue   = r_iss_on && (r_state == ST_APPLY || r_state == ST_SQUARE);

    assign w_idx_ij = 4'({r_i, 1'b0}) + 4'(r_i) + 4'(r_j);
    assign w_idx_ik = 4'({r_i, 1'b0}) + 4'(r_i) + 4'(r_k);
    assign w_idx_kj = 4'({r_k, 1'b0}) + 4'(r_k) + 4'(r_j);

    always_comb begin
        w_iss_tag.last = (r_k == 2'd2);
        if (w_apply) begin
            w_iss_tag.fin = (r_i == 2'd2) && (r_k == 2'd2);
            w_iss_tag.dst = 4'(r_i);
        end else begin
            w_iss_tag.fin = (r_i == 2'd2) && (r_j == 2'd2) && (r_k == 2'd2);
            w_iss_tag.dst = w_idx_ij;
        end
    end

    // tridiagonal transfer matrix, rows of blocked lanes zeroed
    assign w_reach = !((r_i == 2'd0 && r_j == 2'd2) || (r_i == 2'd2 && r_j == 2'd0));

    assign w_sum_raw = {1'b0, r_acc} + {1'b0, w_mul_res};
    assign w_sum     = (w_sum_raw >= (VAL_W+1)'(MODULUS))
                     ? VAL_W'(w_sum_raw - (VAL_W+1)'(MODULUS))
                     : w_sum_raw[VAL_W-1:0];

    assign w_fin  = w_mul_v && w_mul_tag.fin;
    assign w_emit = (r_state == ST_FINISH) && r_last && (!r_out_valid || o_res.ready);

    always_comb begin
        if (r_state == ST_BUILD) begin
            w_we    = 1'b1;
            w_wbank = r_bank;
            w_widx  = w_idx_ij;
            w_wdata = VAL_W'(w_reach && !r_blocked[r_i]);
        end else begin
            w_we    = w_mul_v && w_mul_tag.last && (r_state == ST_SQUARE);
            w_wbank = !r_bank;
            w_widx  = w_mul_tag.dst;
            w_wdata = w_sum;
        end
    end

    // matrix store, two banks so a squaring reads one and writes the other
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_wbank][w_widx] <= w_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_issue) begin
            r_rd_a   <= r_mem[r_bank][w_idx_ik];
            r_rd_b   <= w_apply ? r_vec[r_k] : r_mem[r_bank][w_idx_kj];
            r_rd_tag <= w_iss_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_v <= 1'b0;
        end else begin
            r_rd_v <= w_issue;
        end
    end

    lpcmp_mulmod u_mulmod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_rd_v),
        .i_tag   (r_rd_tag),
        .i_a     (r_rd_a),
        .i_b     (r_rd_b),
        .o_valid (w_mul_v),
        .o_tag   (w_mul_tag),
        .o_res   (w_mul_res)
    );

    // dot product accumulation
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
        end else if (w_mul_v) begin
            r_acc <= w_mul_tag.last ? '0 : w_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_mul_v && w_mul_tag.last && w_apply) begin
            r_vnew[w_mul_tag.dst[1:0]] <= w_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vec[0] <= '0;
            r_vec[1] <= VAL_W'(1);
            r_vec[2] <= '0;
        end else if (w_emit) begin
            r_vec[0] <= '0;
            r_vec[1] <= VAL_W'(1);
            r_vec[2] <= '0;
        end else if (w_fin && w_apply) begin
            r_vec[0] <= r_vnew[0];
            r_vec[1] <= r_vnew[1];
            r_vec[2] <= w_sum;
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_bank      <= 1'b0;
            r_i         <= '0;
            r_j         <= '0;
            r_k         <= '0;
            r_iss_on    <= 1'b0;
            r_exp       <= '0;
            r_blocked   <= '0;
            r_last      <= 1'b0;
            r_out_valid <= 1'b0;
            r_out_count <= '0;
        end else begin
            if (r_out_valid && o_res.ready && !w_emit) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (w_accept) begin
                        r_blocked <= i_seg.blocked_rows;
                        r_exp     <= w_len_ext[LENGTH_BITS-1:0];
                        r_last    <= i_seg.last_segment;
                        r_i       <= '0;
                        r_j       <= '0;
                        r_state   <= ST_BUILD;
                    end
                end
                ST_BUILD: begin
                    if (r_j == 2'd2) begin
                        r_j <= '0;
                        if (r_i == 2'd2) begin
                            r_i     <= '0;
                            r_state <= ST_CHECK;
                        end else begin
                            r_i <= r_i + 2'd1;
                        end
                    end else begin
                        r_j <= r_j + 2'd1;
                    end
                end
                ST_CHECK: begin
                    priority if (r_exp == '0) begin
                        r_state <= ST_FINISH;
                    end else if (r_exp[0]) begin
                        r_i      <= '0;
                        r_j      <= '0;
                        r_k      <= '0;
                        r_iss_on <= 1'b1;
                        r_state  <= ST_APPLY;
                    end else begin
                        r_state <= ST_NEXT;
                    end
                end
                ST_APPLY: begin
                    if (r_iss_on) begin
                        if (r_k == 2'd2) begin
                            r_k <= '0;
                            if (r_i == 2'd2) begin
                                r_i      <= '0;
                                r_iss_on <= 1'b0;
                            end else begin
                                r_i <= r_i + 2'd1;
                            end
                        end else begin
                            r_k <= r_k + 2'd1;
                        end
                    end
                    if (w_fin) begin
                        r_state <= ST_NEXT;
                    end
                end
                ST_NEXT: begin
                    r_exp <= r_exp >> 1;
                    if ((r_exp >> 1) == '0) begin
                        r_state <= ST_FINISH;
                    end else begin
                        r_i      <= '0;
                        r_j      <= '0;
                        r_k      <= '0;
                        r_iss_on <= 1'b1;
                        r_state  <= ST_SQUARE;
                    end
                end
                ST_SQUARE: begin
                    if (r_iss_on) begin
                        if (r_k == 2'd2) begin
                            r_k <= '0;
                            if (r_j == 2'd2) begin
                                r_j <= '0;
                                if (r_i == 2'd2) begin
                                    r_i      <= '0;
                                    r_iss_on <= 1'b0;
                                end else begin
                                    r_i <= r_i + 2'd1;
                                end
                            end else begin
                                r_j <= r_j + 2'd1;
                            end
                        end else begin
                            r_k <= r_k + 2'd1;
                        end
                    end
                    if (w_fin) begin
                        r_bank  <= !r_bank;
                        r_state <= ST_CHECK;
                    end
                end
                ST_FINISH: begin
                    if (!r_last) begin
                        r_state <= ST_IDLE;
                    end else if (w_emit) begin
                        r_out_valid <= 1'b1;
                        r_out_count <= r_vec[1];
                        r_state     <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign i_seg.ready      = (r_state == ST_IDLE);
    assign o_res.valid      = r_out_valid;
    assign o_res.path_count = r_out_count;

endmodule

// ===== design/lpcmp_checker.sv =====
// port-level checks for the lane path counter, bound to the top level
`include "lane_path_count_matrix_power_top_defines.svh"

module lpcmp_checker
    import lpcmp_pkg::*;
(
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_in_valid,
    input logic             i_in_ready,
    input logic             i_out_valid,
    input logic             i_out_ready,
    input logic [VAL_W-1:0] i_path_count
);

    `LPCMP_ASSERT_NEXT(a_busy_after_request, i_clk, i_rst_n, i_in_valid && i_in_ready, !i_in_ready, "ready stayed high after a segment request")
    `LPCMP_ASSERT_NOW(a_count_reduced, i_clk, i_rst_n, i_out_valid, i_path_count < MODULUS, "path count not reduced")
    `LPCMP_ASSERT_NEXT(a_result_held, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid, "result dropped while stalled")
    `LPCMP_ASSERT_NEXT(a_result_stable, i_clk, i_rst_n, i_out_valid && !i_out_ready, $stable(i_path_count), "result changed while stalled")

endmodule

bind lane_path_count_matrix_power_top lpcmp_checker u_lpcmp_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_seg.valid),
    .i_in_ready   (i_seg.ready),
    .i_out_valid  (o_res.valid),
    .i_out_ready  (o_res.ready),
    .i_path_count (o_res.path_count)
);

// ===== bench/lane_path_count_matrix_power_top_test.sv =====
// self-checking testbench for the lane path counter, with a built-in path count predictor
`timescale 1ns / 1ps

module lane_path_count_matrix_power_top_test;
    import lpcmp_pkg::*;

    typedef struct {
        logic [2:0]  blocked;
        logic [59:0] len;
        logic        last;
        bit          drain;
    } seg_req_t;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    lpcmp_seg_if seg_bus ();
    lpcmp_res_if res_bus ();

    lane_path_count_matrix_power_top u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_seg   (seg_bus),
        .o_res   (res_bus)
    );

    seg_req_t    pending_reqs [$];
    seg_req_t    cur_req;
    logic [29:0] exp_counts [$];
    logic [29:0] lane_vec [3];
    int          total_reqs = 1000000;
    int          n_sent = 0;
    int          fails = 0;
    int          hold_left = 0;
    bit          hold_done = 1'b0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        seg_bus.valid = 1'b0;
        seg_bus.blocked_rows = '0;
        seg_bus.segment_length = '0;
        seg_bus.last_segment = 1'b0;
        res_bus.ready = 1'b0;
    end

    function automatic logic [29:0] mul_mod(input logic [29:0] a, input logic [29:0] b);
        logic [63:0] p;
        p = 64'(a) * 64'(b);
        return 30'(p % 64'(MODULUS));
    endfunction

    // advance the lane counts through one segment
    function automatic void apply_segment(input logic [2:0] blocked, input logic [59:0] len);
        logic [29:0] m [9];
        logic [29:0] t [9];
        logic [29:0] v [3];
        logic [63:0] acc;
        logic [59:0] e;
        int i;
        int j;
        int k;
        for (i = 0; i < 3; i++) begin
            for (j = 0; j < 3; j++) begin
                m[i*3+j] = ((i - j <= 1) && (j - i <= 1) && !blocked[i]) ? 30'd1 : 30'd0;
            end
        end
        e = len;
        while (e != 0) begin
            if (e[0]) begin
                for (i = 0; i < 3; i++) begin
                    acc = 0;
                    for (k = 0; k < 3; k++) begin
                        acc = (acc + 64'(mul_mod(m[i*3+k], lane_vec[k]))) % 64'(MODULUS);
                    end
                    v[i] = 30'(acc);
                end
                for (i = 0; i < 3; i++) lane_vec[i] = v[i];
            end
            e = e >> 1;
            if (e != 0) begin
                for (i = 0; i < 3; i++) begin
                    for (j = 0; j < 3; j++) begin
                        acc = 0;
                        for (k = 0; k < 3; k++) begin
                            acc = (acc + 64'(mul_mod(m[i*3+k], m[k*3+j]))) % 64'(MODULUS);
                        end
                        t[i*3+j] = 30'(acc);
                    end
                end
                for (i = 0; i < 9; i++) m[i] = t[i];
            end
        end
    endfunction

    function automatic void reset_lanes();
        lane_vec[0] = 30'd0;
        lane_vec[1] = 30'd1;
        lane_vec[2] = 30'd0;
    endfunction

    function automatic int send_idle_pct();
        if (n_sent < total_reqs / 3) return 12;
        if (n_sent < 2 * total_reqs / 3) return 55;
        return 0;
    endfunction

    function automatic int recv_idle_pct();
        if (n_sent < total_reqs / 3) return 55;
        if (n_sent < 2 * total_reqs / 3) return 12;
        return 0;
    endfunction

    function automatic void add_req(input logic [2:0] blocked, input logic [59:0] len,
                                    input logic last, input bit drain);
        seg_req_t r;
        r.blocked = blocked;
        r.len = len;
        r.last = last;
        r.drain = drain;
        pending_reqs.push_back(r);
    endfunction

    function automatic logic [59:0] rand_length();
        logic [63:0] v;
        int bits;
        v = {$urandom, $urandom};
        if ($urandom_range(99) < 25) return v[59:0];
        bits = $urandom_range(0, 16);
        return 60'(v & ((64'd1 << bits) - 64'd1));
    endfunction

    // driver
    always @(posedge i_clk) begin
        bit busy;
        bit go;
        if (!i_rst_n) begin
            seg_bus.valid <= 1'b0;
            reset_lanes();
        end else begin
            busy = seg_bus.valid;
            if (seg_bus.valid && seg_bus.ready) begin
                apply_segment(cur_req.blocked, cur_req.len);
                if (cur_req.last) begin
                    exp_counts.push_back(lane_vec[1]);
                    reset_lanes();
                end
                n_sent++;
                busy = 1'b0;
            end
            if (!busy) begin
                go = pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct();
                if (go && pending_reqs[0].drain && exp_counts.size() != 0) go = 1'b0;
                if (go) begin
                    cur_req = pending_reqs.pop_front();
                    seg_bus.valid <= 1'b1;
                    seg_bus.blocked_rows <= cur_req.blocked;
                    seg_bus.segment_length <= cur_req.len;
                    seg_bus.last_segment <= cur_req.last;
                end else begin
                    seg_bus.valid <= 1'b0;
                end
            end
        end
    end

    // long receiver hold-off once the idle-free phase is under way
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (!hold_done && n_sent >= 2 * total_reqs / 3 + 5) begin
            hold_left <= 6000;
            hold_done <= 1'b1;
        end
    end

    // monitor
    always @(posedge i_clk) begin
        logic [29:0] want;
        if (!i_rst_n) begin
            res_bus.ready <= 1'b0;
        end else begin
            if (res_bus.valid && res_bus.ready) begin
                if (exp_counts.size() == 0) begin
                    $error("unexpected result: path_count actual %0d", res_bus.path_count);
                    fails++;
                end else begin
                    want = exp_counts.pop_front();
                    if (res_bus.path_count !== want) begin
                        $error("path_count mismatch: expected %0d actual %0d",
                               want, res_bus.path_count);
                        fails++;
                    end
                end
            end
            res_bus.ready <= (hold_left == 0) && ($urandom_range(99) >= recv_idle_pct());
        end
    end

    initial begin
        int n_segs;
        int s;
        bit first;
        add_req(3'd0, 60'd0, 1'b1, 1'b0);
        add_req(3'd0, 60'd1, 1'b1, 1'b0);
        add_req(3'd0, {60{1'b1}}, 1'b1, 1'b0);
        add_req(3'd0, 60'd1000000000000000000, 1'b1, 1'b0);
        add_req(3'd7, 60'd5, 1'b0, 1'b0);
        add_req(3'd0, 60'd3, 1'b1, 1'b0);
        add_req(3'd7, 60'd0, 1'b1, 1'b0);
        for (s = 1; s < 6; s++) add_req(3'(s), 60'(10 + s), 1'b0, 1'b0);
        add_req(3'd6, 60'd1, 1'b1, 1'b0);
        add_req(3'd0, 60'hAAAAAAAAAAAAAAA, 1'b0, 1'b0);
        add_req(3'd2, 60'h555555555555555, 1'b1, 1'b0);
        add_req(3'd5, 60'd1, 1'b1, 1'b0);
        add_req(3'd7, {60{1'b1}}, 1'b1, 1'b0);
        first = 1'b1;
        while (pending_reqs.size() < 270) begin
            n_segs = $urandom_range(1, 4);
            for (s = 0; s < n_segs; s++) begin
                add_req(($urandom_range(1) == 0) ? 3'd0 : 3'($urandom_range(7)),
                        rand_length(), s == n_segs - 1, first);
                first = 1'b0;
            end
        end
        total_reqs = pending_reqs.size();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        while (pending_reqs.size() != 0 || seg_bus.valid) @(posedge i_clk);
        while (exp_counts.size() != 0) @(posedge i_clk);
        repeat (3500) @(posedge i_clk);
        if (fails == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    initial begin
        #40ms;
        $display("TEST FAILED");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+design
design/lpcmp_pkg.sv
design/lpcmp_if.sv
design/lpcmp_mulmod.sv
design/lane_path_count_matrix_power_top.sv
design/lpcmp_checker.sv
bench/lane_path_count_matrix_power_top_test.sv
